>>> design/sbcfl_pkg.sv
// shared constants, types and codes for the byte-capacity block cache
package sbcfl_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int PAGE_BYTES  = 4096;
  localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
  localparam int KEY_W       = 16;
  localparam int SIZE_W      = 40;
  localparam int PCNT_W      = 48;
  localparam int DEM_W       = SIZE_W + 2;
  localparam int OP_W        = 2;
  localparam int ENTRY_W     = 2 * KEY_W + SIZE_W;
  localparam int PADDR_W     = 5;
  localparam int PDATA_W     = 64;

  localparam logic [SIZE_W-1:0] CAP_RESET = 40'd1073741824;

  // operation codes
  localparam logic [OP_W-1:0] OP_ACCESS = 2'd0;
  localparam logic [OP_W-1:0] OP_INVAL  = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
  localparam logic [OP_W-1:0] OP_RSVD   = 2'd3;

  // register indexes
  localparam logic [1:0] REG_CAPACITY = 2'd0;
  localparam logic [1:0] REG_NEWEST   = 2'd1;
  localparam logic [1:0] REG_PARTIAL  = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0]  row;
    logic [KEY_W-1:0]  col;
    logic [SIZE_W-1:0] bytes;
  } entry_t;

  typedef struct packed {
    logic [SIZE_W-1:0] capacity;
    logic              newest;
    logic              partial;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DISPATCH, ST_SCAN_RD, ST_SCAN_CMP, ST_EV_CHECK, ST_EV_RD, ST_EV_DEC,
    ST_DROP_RD, ST_DROP_SUB, ST_SH_RD, ST_SH_WR, ST_INSERT, ST_STAT, ST_DONE
  } state_e;

  typedef enum logic [1:0] {PTR_HOLD, PTR_ZERO, PTR_INC, PTR_VICTIM} ptr_op_e;
  typedef enum logic {RD_PTR, RD_NEXT} rd_sel_e;
  typedef enum logic [1:0] {WR_NONE, WR_SHIFT, WR_SHRINK, WR_INSERT} wr_op_e;
  typedef enum logic [1:0] {HELD_NONE, HELD_SUB_RD, HELD_SUB_DIFF, HELD_ADD_INS} held_op_e;
  typedef enum logic [1:0] {CNT_NONE, CNT_DEC, CNT_INC} cnt_op_e;

  typedef struct packed {
    logic     ld_in;
    ptr_op_e  ptr_op;
    rd_sel_e  rd_sel;
    wr_op_e   wr_op;
    held_op_e held_op;
    cnt_op_e  cnt_op;
    logic     hit_cap;
    logic     set_rm;
    logic     stat_upd;
    logic     res_ld;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            size_zero;
    logic            cnt_zero;
    logic            full;
    logic            scan_end;
    logic            next_end;
    logic            match;
    logic            over;
    logic            shrink_ok;
    logic            partial;
    logic            hit;
  } stat_t;

endpackage

>>> design/sized_block_cache_fifo_lifo.sv
// top level: register port, sequencer and datapath of the block cache
// An item is taken when start is high and busy is low; busy then stays high
// until the result, which is shown for one cycle with done_o high as busy
// falls. The key search walks the entry table in a ram with separate read and
// write ports, and every whole-entry removal moves the younger entries down
// one place. One access that empties a full table oldest first moves about
// 2000 entries. The receiver cannot stall the result.
module sized_block_cache_fifo_lifo (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sbcfl_pkg::PADDR_W-1:0]     paddr,
  input  logic [sbcfl_pkg::PDATA_W-1:0]     pwdata,
  output logic [sbcfl_pkg::PDATA_W-1:0]     prdata,
  output logic                              pready,
  input  logic                              start,
  output logic                              busy,
  input  logic [sbcfl_pkg::OP_W-1:0]        op_i,
  input  logic [sbcfl_pkg::KEY_W-1:0]       row_i,
  input  logic [sbcfl_pkg::KEY_W-1:0]       col_i,
  input  logic [sbcfl_pkg::SIZE_W-1:0]      block_size_i,
  output logic                              done_o,
  output logic [sbcfl_pkg::SIZE_W-1:0]      fetch_bytes_o,
  output logic                              was_hit_o,
  output logic                              removed_o,
  output logic [sbcfl_pkg::SIZE_W-1:0]      used_bytes_o,
  output logic [sbcfl_pkg::PCNT_W-1:0]      hit_pages_o,
  output logic [sbcfl_pkg::PCNT_W-1:0]      total_pages_o
);

  sbcfl_pkg::cfg_t  cfg_q;
  sbcfl_pkg::cmd_t  cmd;
  sbcfl_pkg::stat_t stat;
  logic             wr_en;
  logic [1:0]       reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:3];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.capacity <= sbcfl_pkg::CAP_RESET;
      cfg_q.newest   <= 1'b0;
      cfg_q.partial  <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        sbcfl_pkg::REG_CAPACITY: cfg_q.capacity <= pwdata[sbcfl_pkg::SIZE_W-1:0];
        sbcfl_pkg::REG_NEWEST:   cfg_q.newest   <= pwdata[0];
        sbcfl_pkg::REG_PARTIAL:  cfg_q.partial  <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (reg_idx)
      sbcfl_pkg::REG_CAPACITY: prdata = sbcfl_pkg::PDATA_W'(cfg_q.capacity);
      sbcfl_pkg::REG_NEWEST:   prdata = sbcfl_pkg::PDATA_W'(cfg_q.newest);
      sbcfl_pkg::REG_PARTIAL:  prdata = sbcfl_pkg::PDATA_W'(cfg_q.partial);
      default:                 prdata = '0;
    endcase
  end

  sbcfl_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  sbcfl_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .op_i         (op_i),
    .row_i        (row_i),
    .col_i        (col_i),
    .block_size_i (block_size_i),
    .done_o       (done_o),
    .fetch_bytes_o(fetch_bytes_o),
    .was_hit_o    (was_hit_o),
    .removed_o    (removed_o),
    .used_bytes_o (used_bytes_o),
    .hit_pages_o  (hit_pages_o),
    .total_pages_o(total_pages_o)
  );

`ifndef NO_ASSERTIONS
  // a result transfer ends the item
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result shown while busy");
  // an accepted item keeps the block busy
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("item accepted but not busy");
  // one result per item
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");
  // entry count never exceeds the table
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(stat.full && cmd.cnt_op == sbcfl_pkg::CNT_INC)) else $error("table overflow");
`endif

endmodule

>>> design/sbcfl_ram.sv
// generic single-write, single-read ram with registered read data
module sbcfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/sbcfl_ctrl.sv
// sequencer for lookup, eviction, table shift and insertion
module sbcfl_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  sbcfl_pkg::stat_t stat_i,
  output sbcfl_pkg::cmd_t  cmd_o,
  output logic             busy_o
);

  sbcfl_pkg::state_e state_q, state_d;
  sbcfl_pkg::state_e ret_q, ret_d;

  // state and return registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sbcfl_pkg::ST_IDLE;
      ret_q   <= sbcfl_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d        = state_q;
    ret_d          = ret_q;
    cmd_o          = '0;
    cmd_o.ptr_op   = sbcfl_pkg::PTR_HOLD;
    cmd_o.rd_sel   = sbcfl_pkg::RD_PTR;
    cmd_o.wr_op    = sbcfl_pkg::WR_NONE;
    cmd_o.held_op  = sbcfl_pkg::HELD_NONE;
    cmd_o.cnt_op   = sbcfl_pkg::CNT_NONE;
    busy_o         = (state_q != sbcfl_pkg::ST_IDLE);
    case (state_q)
      sbcfl_pkg::ST_IDLE: begin
        if (start_i) begin
          cmd_o.ld_in  = 1'b1;
          cmd_o.ptr_op = sbcfl_pkg::PTR_ZERO;
          state_d      = sbcfl_pkg::ST_DISPATCH;
        end
      end
      sbcfl_pkg::ST_DISPATCH: begin
        case (stat_i.op)
          sbcfl_pkg::OP_ACCESS: begin
            state_d = stat_i.size_zero ? sbcfl_pkg::ST_DONE : sbcfl_pkg::ST_SCAN_RD;
          end
          sbcfl_pkg::OP_INVAL: begin
            state_d = sbcfl_pkg::ST_SCAN_RD;
          end
          sbcfl_pkg::OP_REMOVE: begin
            if (!stat_i.cnt_zero) begin
              cmd_o.set_rm = 1'b1;
              ret_d        = sbcfl_pkg::ST_DONE;
              state_d      = sbcfl_pkg::ST_DROP_RD;
            end else begin
              state_d = sbcfl_pkg::ST_DONE;
            end
          end
          default: state_d = sbcfl_pkg::ST_DONE;
        endcase
      end
      // key search, reading and then comparing each entry
      sbcfl_pkg::ST_SCAN_RD: begin
        if (stat_i.scan_end) begin
          state_d = (stat_i.op == sbcfl_pkg::OP_ACCESS) ? sbcfl_pkg::ST_EV_CHECK
                                                         : sbcfl_pkg::ST_DONE;
        end else begin
          state_d = sbcfl_pkg::ST_SCAN_CMP;
        end
      end
      sbcfl_pkg::ST_SCAN_CMP: begin
        if (stat_i.match) begin
          if (stat_i.op == sbcfl_pkg::OP_ACCESS) begin
            cmd_o.hit_cap = 1'b1;
            state_d = stat_i.partial ? sbcfl_pkg::ST_EV_CHECK : sbcfl_pkg::ST_STAT;
          end else begin
            cmd_o.held_op = sbcfl_pkg::HELD_SUB_RD;
            cmd_o.set_rm  = 1'b1;
            ret_d         = sbcfl_pkg::ST_DONE;
            state_d       = sbcfl_pkg::ST_SH_RD;
          end
        end else begin
          cmd_o.ptr_op = sbcfl_pkg::PTR_INC;
          state_d      = sbcfl_pkg::ST_SCAN_RD;
        end
      end
      // eviction loop
      sbcfl_pkg::ST_EV_CHECK: begin
        if (!stat_i.cnt_zero && stat_i.over) begin
          cmd_o.ptr_op = sbcfl_pkg::PTR_VICTIM;
          state_d      = sbcfl_pkg::ST_EV_RD;
        end else if (stat_i.hit) begin
          state_d = sbcfl_pkg::ST_STAT;
        end else if (stat_i.full) begin
          cmd_o.ptr_op = sbcfl_pkg::PTR_VICTIM;
          ret_d        = sbcfl_pkg::ST_INSERT;
          state_d      = sbcfl_pkg::ST_DROP_RD;
        end else begin
          state_d = sbcfl_pkg::ST_INSERT;
        end
      end
      sbcfl_pkg::ST_EV_RD: begin
        state_d = sbcfl_pkg::ST_EV_DEC;
      end
      sbcfl_pkg::ST_EV_DEC: begin
        if (stat_i.shrink_ok) begin
          cmd_o.wr_op   = sbcfl_pkg::WR_SHRINK;
          cmd_o.held_op = sbcfl_pkg::HELD_SUB_DIFF;
          state_d       = sbcfl_pkg::ST_EV_CHECK;
        end else begin
          cmd_o.held_op = sbcfl_pkg::HELD_SUB_RD;
          ret_d         = sbcfl_pkg::ST_EV_CHECK;
          state_d       = sbcfl_pkg::ST_SH_RD;
        end
      end
      // whole-entry removal at the pointer
      sbcfl_pkg::ST_DROP_RD: begin
        state_d = sbcfl_pkg::ST_DROP_SUB;
      end
      sbcfl_pkg::ST_DROP_SUB: begin
        cmd_o.held_op = sbcfl_pkg::HELD_SUB_RD;
        state_d       = sbcfl_pkg::ST_SH_RD;
      end
      // close the gap, reading and then writing each entry
      sbcfl_pkg::ST_SH_RD: begin
        if (stat_i.next_end) begin
          cmd_o.cnt_op = sbcfl_pkg::CNT_DEC;
          state_d      = ret_q;
        end else begin
          cmd_o.rd_sel = sbcfl_pkg::RD_NEXT;
          state_d      = sbcfl_pkg::ST_SH_WR;
        end
      end
      sbcfl_pkg::ST_SH_WR: begin
        cmd_o.wr_op  = sbcfl_pkg::WR_SHIFT;
        cmd_o.ptr_op = sbcfl_pkg::PTR_INC;
        state_d      = sbcfl_pkg::ST_SH_RD;
      end
      sbcfl_pkg::ST_INSERT: begin
        cmd_o.wr_op   = sbcfl_pkg::WR_INSERT;
        cmd_o.held_op = sbcfl_pkg::HELD_ADD_INS;
        cmd_o.cnt_op  = sbcfl_pkg::CNT_INC;
        state_d       = sbcfl_pkg::ST_STAT;
      end
      sbcfl_pkg::ST_STAT: begin
        cmd_o.stat_upd = 1'b1;
        state_d        = sbcfl_pkg::ST_DONE;
      end
      sbcfl_pkg::ST_DONE: begin
        cmd_o.res_ld = 1'b1;
        state_d      = sbcfl_pkg::ST_IDLE;
      end
      default: state_d = sbcfl_pkg::ST_IDLE;
    endcase
  end

endmodule

>>> design/sbcfl_dpath.sv
// entry table, byte accounting, page counters and result fields
module sbcfl_dpath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sbcfl_pkg::cfg_t                   cfg_i,
  input  sbcfl_pkg::cmd_t                   cmd_i,
  output sbcfl_pkg::stat_t                  stat_o,
  input  logic [sbcfl_pkg::OP_W-1:0]        op_i,
  input  logic [sbcfl_pkg::KEY_W-1:0]       row_i,
  input  logic [sbcfl_pkg::KEY_W-1:0]       col_i,
  input  logic [sbcfl_pkg::SIZE_W-1:0]      block_size_i,
  output logic                              done_o,
  output logic [sbcfl_pkg::SIZE_W-1:0]      fetch_bytes_o,
  output logic                              was_hit_o,
  output logic                              removed_o,
  output logic [sbcfl_pkg::SIZE_W-1:0]      used_bytes_o,
  output logic [sbcfl_pkg::PCNT_W-1:0]      hit_pages_o,
  output logic [sbcfl_pkg::PCNT_W-1:0]      total_pages_o
);

  logic [sbcfl_pkg::OP_W-1:0]          op_q;
  logic [sbcfl_pkg::KEY_W-1:0]         row_q, col_q;
  logic [sbcfl_pkg::SIZE_W-1:0]        size_q, cur_q;
  logic signed [sbcfl_pkg::DEM_W-1:0]  dem_q;
  logic                                hit_q, rm_q, done_q;
  logic [sbcfl_pkg::CNT_W-1:0]         ptr_q, ptr_d, cnt_q, cnt_d;
  logic [sbcfl_pkg::SIZE_W-1:0]        held_q, held_d;
  logic [sbcfl_pkg::PCNT_W-1:0]        hitpg_q, totpg_q;

  logic [sbcfl_pkg::ENTRY_W-1:0]       rdata;
  sbcfl_pkg::entry_t                   rd_ent, wr_ent;
  logic                                we;
  logic [sbcfl_pkg::ADDR_W-1:0]        waddr, raddr;
  logic [sbcfl_pkg::CNT_W-1:0]         ptr_next, victim;
  logic signed [sbcfl_pkg::DEM_W-1:0]  held_s, cap_s, sum_s, diff_s, rem_s;
  logic [sbcfl_pkg::SIZE_W-1:0]        ins_b, diff;

  assign rd_ent   = sbcfl_pkg::entry_t'(rdata);
  assign ptr_next = ptr_q + 1'b1;
  assign victim   = cfg_i.newest ? (cnt_q - 1'b1) : '0;
  assign held_s   = $signed({2'b00, held_q});
  assign cap_s    = $signed({2'b00, cfg_i.capacity});
  assign sum_s    = held_s + dem_q;
  assign diff_s   = sum_s - cap_s;
  assign diff     = diff_s[sbcfl_pkg::SIZE_W-1:0];
  assign rem_s    = held_s - $signed({2'b00, rd_ent.bytes}) + dem_q;
  assign ins_b    = (size_q > cfg_i.capacity) ? cfg_i.capacity : size_q;

  // status toward the sequencer
  always_comb begin
    stat_o.op        = op_q;
    stat_o.size_zero = (size_q == '0);
    stat_o.cnt_zero  = (cnt_q == '0);
    stat_o.full      = (cnt_q == sbcfl_pkg::CNT_W'(sbcfl_pkg::MAX_ENTRIES));
    stat_o.scan_end  = (ptr_q >= cnt_q);
    stat_o.next_end  = (ptr_next >= cnt_q);
    stat_o.match     = (rd_ent.row == row_q) && (rd_ent.col == col_q);
    stat_o.over      = (sum_s > cap_s);
    stat_o.shrink_ok = cfg_i.partial && (rem_s < cap_s);
    stat_o.partial   = cfg_i.partial;
    stat_o.hit       = hit_q;
  end

  // table port selection
  always_comb begin
    raddr  = (cmd_i.rd_sel == sbcfl_pkg::RD_NEXT) ? ptr_next[sbcfl_pkg::ADDR_W-1:0]
                                                  : ptr_q[sbcfl_pkg::ADDR_W-1:0];
    we     = 1'b0;
    waddr  = ptr_q[sbcfl_pkg::ADDR_W-1:0];
    wr_ent = rd_ent;
    case (cmd_i.wr_op)
      sbcfl_pkg::WR_SHIFT: we = 1'b1;
      sbcfl_pkg::WR_SHRINK: begin
        we           = 1'b1;
        wr_ent.bytes = rd_ent.bytes - diff;
      end
      sbcfl_pkg::WR_INSERT: begin
        we           = 1'b1;
        waddr        = cnt_q[sbcfl_pkg::ADDR_W-1:0];
        wr_ent.row   = row_q;
        wr_ent.col   = col_q;
        wr_ent.bytes = ins_b;
      end
      default: we = 1'b0;
    endcase
  end

  sbcfl_ram #(
    .WIDTH(sbcfl_pkg::ENTRY_W),
    .DEPTH(sbcfl_pkg::MAX_ENTRIES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wr_ent),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // pointer, count and held bytes next values
  always_comb begin
    case (cmd_i.ptr_op)
      sbcfl_pkg::PTR_ZERO:   ptr_d = '0;
      sbcfl_pkg::PTR_INC:    ptr_d = ptr_next;
      sbcfl_pkg::PTR_VICTIM: ptr_d = victim;
      default:               ptr_d = ptr_q;
    endcase
    case (cmd_i.cnt_op)
      sbcfl_pkg::CNT_DEC: cnt_d = cnt_q - 1'b1;
      sbcfl_pkg::CNT_INC: cnt_d = cnt_q + 1'b1;
      default:            cnt_d = cnt_q;
    endcase
    case (cmd_i.held_op)
      sbcfl_pkg::HELD_SUB_RD:   held_d = held_q - rd_ent.bytes;
      sbcfl_pkg::HELD_SUB_DIFF: held_d = held_q - diff;
      sbcfl_pkg::HELD_ADD_INS:  held_d = held_q + ins_b;
      default:                  held_d = held_q;
    endcase
  end

  // control and accounting registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q   <= '0;
      cnt_q   <= '0;
      held_q  <= '0;
      hitpg_q <= '0;
      totpg_q <= '0;
      hit_q   <= 1'b0;
      rm_q    <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      ptr_q  <= ptr_d;
      cnt_q  <= cnt_d;
      held_q <= held_d;
      done_q <= cmd_i.res_ld;
      if (cmd_i.ld_in) begin
        hit_q <= 1'b0;
        rm_q  <= 1'b0;
      end else begin
        if (cmd_i.hit_cap) hit_q <= 1'b1;
        if (cmd_i.set_rm)  rm_q  <= 1'b1;
      end
      if (cmd_i.stat_upd) begin
        totpg_q <= totpg_q + sbcfl_pkg::PCNT_W'(size_q >> sbcfl_pkg::PAGE_SHIFT);
        if (hit_q) begin
          hitpg_q <= hitpg_q + sbcfl_pkg::PCNT_W'(cur_q >> sbcfl_pkg::PAGE_SHIFT);
        end
      end
    end
  end

  // item payload and demand
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) begin
      op_q   <= op_i;
      row_q  <= row_i;
      col_q  <= col_i;
      size_q <= block_size_i;
      dem_q  <= $signed({2'b00, block_size_i});
    end else if (cmd_i.hit_cap) begin
      cur_q  <= rd_ent.bytes;
      dem_q  <= $signed({2'b00, size_q}) - $signed({2'b00, rd_ent.bytes});
    end
  end

  // result fields, stable while idle
  always_comb begin
    fetch_bytes_o = '0;
    if (op_q == sbcfl_pkg::OP_ACCESS && size_q != '0) begin
      if (!hit_q) begin
        fetch_bytes_o = size_q;
      end else if (size_q > cur_q) begin
        fetch_bytes_o = size_q - cur_q;
      end
    end
  end

  assign done_o        = done_q;
  assign was_hit_o     = hit_q;
  assign removed_o     = rm_q;
  assign used_bytes_o  = held_q;
  assign hit_pages_o   = hitpg_q;
  assign total_pages_o = totpg_q;

endmodule
